/* design/bpts_pkg.sv */
// Package for the bitmap priority task scheduler.
// Holds the transfer payload types, event codes, controller/datapath
// command and status structs, and the small helper functions.
`timescale 1ns / 1ps

package bpts_pkg;

    // Event codes carried in the kind field
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_YIELD  = 2'd1;
    localparam logic [1:0] KIND_SLEEP  = 2'd2;
    localparam logic [1:0] KIND_SWITCH = 2'd3;

    // Wakeup value that means "not sleeping"
    localparam logic [63:0] NO_WAKE = 64'hFFFF_FFFF_FFFF_FFFF;

    // Input transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] now_ticks;
        logic [30:0] sleep_ms;
    } t_in_item;

    // Result transfer
    typedef struct packed {
        logic        switch_request;
        logic [2:0]  next_task;
        logic [2:0]  running_task;
        logic [7:0]  ready_tasks;
        logic [7:0]  pending_tasks;
    } t_out_item;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // capture event
        logic sum;        // wakeup sum into register
        logic wr_wake;    // store wakeup time of running task
        logic file;       // file ejected tasks, clear scan
        logic reclaim;    // next task goes back to ready, clear scan
        logic wake_step;  // one task of the wake scan
        logic pick_step;  // one task of the priority scan
        logic fallback;   // choose first ready task
        logic done_sw;    // context switch finished
        logic emit;       // register the result
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic [1:0] kind;
        logic       ready_zero;
        logic       pend_zero;
        logic       last;
        logic       woke;
        logic       pick_hit;
        logic       cur_sleep;
    } t_sts;

    // Lowest set bit of an eight-bit mask, zero when empty
    function automatic logic [2:0] low_index(input logic [7:0] m);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Eight-bit priority of task t
    function automatic logic [7:0] prio_of(input logic [63:0] tbl, input logic [2:0] t);
        logic [63:0] sh;
        sh = tbl >> {t, 3'b000};
        return sh[7:0];
    endfunction

endpackage

/* design/bpts_ctrl.sv */
// Controller state machine of the bitmap priority task scheduler.
// Sequences the per-event steps; drives bpts_pkg::t_cmd, reads bpts_pkg::t_sts.
`timescale 1ns / 1ps

module bpts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bpts_pkg::t_sts  i_sts,
    output bpts_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_WRITE,
        ST_FILE,
        ST_CHECK,
        ST_WAKE,
        ST_WAKE_END,
        ST_PICK,
        ST_SWITCH,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Sleep events pass the routing state twice: once before the sum, once to file
    logic   r_busy_sleep_done;

    assign busy = r_busy;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_FILE;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr_wake = 1'b1;
                n_state       = ST_FILE;
            end
            ST_FILE: begin
                // routing state, entered after the transfer and again after a sleep's store: route by event
                if (i_sts.kind == bpts_pkg::KIND_SWITCH) begin
                    n_state = ST_SWITCH;
                end else if (i_sts.kind == bpts_pkg::KIND_SLEEP && !r_busy_sleep_done) begin
                    n_state = ST_SUM;
                end else begin
                    o_cmd.file    = 1'b1;
                    o_cmd.reclaim = (i_sts.kind != bpts_pkg::KIND_TICK);
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.kind == bpts_pkg::KIND_TICK) begin
                    n_state = i_sts.pend_zero ? ST_EMIT : ST_WAKE;
                end else begin
                    n_state = i_sts.ready_zero ? ST_EMIT : ST_PICK;
                end
            end
            ST_WAKE: begin
                o_cmd.wake_step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_WAKE_END;
                end
            end
            ST_WAKE_END: begin
                if (i_sts.woke) begin
                    o_cmd.reclaim = 1'b1;
                    n_state       = ST_PICK;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_PICK: begin
                o_cmd.pick_step = 1'b1;
                // no eligible task: a sleeping yielder takes the first ready task
                o_cmd.fallback  = !i_sts.pick_hit && i_sts.last &&
                                  (i_sts.kind != bpts_pkg::KIND_TICK) && i_sts.cur_sleep;
                if (i_sts.pick_hit || i_sts.last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SWITCH: begin
                o_cmd.done_sw = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_busy            <= 1'b0;
            r_busy_sleep_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && start) begin
                r_busy            <= 1'b1;
                r_busy_sleep_done <= 1'b0;
            end else if (r_state == ST_WRITE) begin
                r_busy_sleep_done <= 1'b1;
            end else if (r_state == ST_EMIT) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* design/bpts_dp.sv */
// Datapath of the bitmap priority task scheduler: task masks, wakeup times,
// priority register, scan counter and result register. Uses bpts_pkg.
`timescale 1ns / 1ps

module bpts_dp #(
    parameter int NUM_TASKS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpts_pkg::t_in_item i_item,
    input  logic               i_cfg_we,
    input  logic [63:0]        i_cfg_wdata,
    input  bpts_pkg::t_cmd     i_cmd,
    output bpts_pkg::t_sts     o_sts,
    output logic               o_valid,
    output bpts_pkg::t_out_item o_result
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // Event and configuration
    logic [1:0]           r_kind;
    logic [63:0]          r_now;
    logic [30:0]          r_ms;
    logic [63:0]          r_sum;
    logic [63:0]          r_prio;

    // Task state
    logic [63:0]          r_wake [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_sleep, n_sleep;
    logic [NUM_TASKS-1:0] r_ready, n_ready;
    logic [NUM_TASKS-1:0] r_pend,  n_pend;
    logic [NUM_TASKS-1:0] r_run,   n_run;
    logic [NUM_TASKS-1:0] r_next,  n_next;
    logic [NUM_TASKS-1:0] r_ej,    n_ej;

    // Scan
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic                 r_woke, n_woke;
    logic                 r_req, n_req;

    // Result
    logic                 r_valid;
    bpts_pkg::t_out_item  r_out;

    logic [2:0]           w_cur;
    logic [IDX_W-1:0]     w_cur_i;
    logic [7:0]           w_prio_cur;
    logic [7:0]           w_prio_cnt;
    logic [NUM_TASKS-1:0] w_cnt_bit;
    logic [NUM_TASKS-1:0] w_fb_bit;
    logic                 w_wake_hit;
    logic                 w_pick_hit;

    // Running task and scan-slot decode
    assign w_cur      = bpts_pkg::low_index(8'(r_run));
    assign w_cur_i    = w_cur[IDX_W-1:0];
    assign w_prio_cur = bpts_pkg::prio_of(r_prio, w_cur);
    assign w_prio_cnt = bpts_pkg::prio_of(r_prio, 3'(r_cnt));
    assign w_cnt_bit  = NUM_TASKS'(1) << r_cnt;
    assign w_fb_bit   = NUM_TASKS'(1) << bpts_pkg::low_index(8'(r_ready));
    assign w_wake_hit = r_pend[r_cnt] && (r_now > r_wake[r_cnt]);
    assign w_pick_hit = r_ready[r_cnt] && (w_prio_cnt >= w_prio_cur);

    // Status to controller
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.ready_zero = (r_ready == '0);
        o_sts.pend_zero  = (r_pend == '0);
        o_sts.last       = (r_cnt == IDX_W'(NUM_TASKS - 1));
        o_sts.woke       = r_woke;
        o_sts.pick_hit   = w_pick_hit;
        o_sts.cur_sleep  = r_sleep[w_cur_i];
    end

    // Mask updates
    always_comb begin
        n_ready = r_ready;
        n_pend  = r_pend;
        n_run   = r_run;
        n_next  = r_next;
        n_ej    = r_ej;
        n_sleep = r_sleep;
        n_cnt   = r_cnt;
        n_woke  = r_woke;
        n_req   = r_req;
        // a new event starts with no switch request
        if (i_cmd.load) begin
            n_req = 1'b0;
        end
        // file ejected tasks by their sleep flag
        if (i_cmd.file) begin
            n_pend  = n_pend | (r_ej & r_sleep);
            n_ready = n_ready | (r_ej & ~r_sleep);
            n_ej    = '0;
            n_cnt   = '0;
            n_woke  = 1'b0;
            n_req   = 1'b0;
        end
        // pending switch target competes again
        if (i_cmd.reclaim) begin
            n_ready = n_ready | r_next;
            n_next  = '0;
            n_cnt   = '0;
        end
        if (i_cmd.wr_wake) begin
            n_sleep[w_cur_i] = (r_sum != bpts_pkg::NO_WAKE);
        end
        // wake scan: one task per cycle
        if (i_cmd.wake_step) begin
            if (w_wake_hit) begin
                n_sleep[r_cnt] = 1'b0;
                n_pend[r_cnt]  = 1'b0;
                n_ready[r_cnt] = 1'b1;
                n_woke         = 1'b1;
            end
            n_cnt = r_cnt + IDX_W'(1);
        end
        // priority scan: one task per cycle
        if (i_cmd.pick_step) begin
            if (w_pick_hit) begin
                n_next  = w_cnt_bit;
                n_ready = r_ready & ~w_cnt_bit;
                n_req   = 1'b1;
            end
            n_cnt = r_cnt + IDX_W'(1);
        end
        if (i_cmd.fallback) begin
            n_next  = w_fb_bit;
            n_ready = r_ready & ~w_fb_bit;
            n_req   = 1'b1;
        end
        // context switch done: if a next task is set, it runs and old running is ejected
        if (i_cmd.done_sw && (r_next != '0)) begin
            n_ej   = r_ej | r_run;
            n_run  = r_next;
            n_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= {NUM_TASKS{1'b1}} & ~NUM_TASKS'(1);
            r_pend  <= '0;
            r_run   <= NUM_TASKS'(1);
            r_next  <= '0;
            r_ej    <= '0;
            r_sleep <= '0;
            r_cnt   <= '0;
            r_woke  <= 1'b0;
            r_req   <= 1'b0;
            r_prio  <= '0;
            r_valid <= 1'b0;
            r_kind  <= bpts_pkg::KIND_TICK;
        end else begin
            r_ready <= n_ready;
            r_pend  <= n_pend;
            r_run   <= n_run;
            r_next  <= n_next;
            r_ej    <= n_ej;
            r_sleep <= n_sleep;
            r_cnt   <= n_cnt;
            r_woke  <= n_woke;
            r_req   <= n_req;
            r_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                r_prio <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_kind <= i_item.kind;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_item.now_ticks;
            r_ms  <= i_item.sleep_ms;
        end
        if (i_cmd.sum) begin
            r_sum <= r_now + 64'(r_ms);
        end
        if (i_cmd.wr_wake) begin
            r_wake[w_cur_i] <= r_sum;
        end
        if (i_cmd.emit) begin
            r_out.switch_request <= r_req;
            r_out.next_task      <= r_req ? bpts_pkg::low_index(8'(r_next)) : 3'd0;
            r_out.running_task   <= w_cur;
            r_out.ready_tasks    <= 8'(r_ready);
            r_out.pending_tasks  <= 8'(r_pend);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

/* design/bitmap_priority_task_scheduler.sv */
// Top level of the bitmap priority task scheduler.
// Joins bpts_ctrl and bpts_dp; payload types from bpts_pkg.
`timescale 1ns / 1ps

// An event is taken when start is high and busy is low. Every event gives one
// result, shown for a single cycle with o_valid high in the cycle in which
// busy falls; the receiver cannot stall it, so sample it on that cycle. A tick
// runs a wake scan when a task is pending and, if a task woke, a priority
// scan, one task per cycle each. A yield runs only the priority scan; a sleep
// adds the wakeup sum, its store and a second routing pass; a switch-done
// event goes from routing to the switch and then to the result. The next
// event can be taken in the cycle the result shows. The priority register must
// be written by the user with i_cfg_we and i_cfg_wdata only while busy is low
// and no result is due; the block itself does not enforce this.
module bitmap_priority_task_scheduler #(
    parameter int NUM_TASKS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bpts_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [63:0]         i_cfg_wdata,
    output logic                o_valid,
    output bpts_pkg::t_out_item o_result
);

    bpts_pkg::t_cmd w_cmd;
    bpts_pkg::t_sts w_sts;

    // Event sequencer
    bpts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Task state and scans
    bpts_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule
